// ----- rtl/core/fbpa_pkg.sv -----
// Package for the fixed block pool allocator: widths, register indexes,
// reset values, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS  = 1024;
  localparam int IDX_W       = 10;
  localparam int HEAD_W      = 11;
  localparam int ALIGN_BYTES = 16;
  localparam int ALIGN_LG    = 4;
  localparam logic [HEAD_W-1:0] LIST_EMPTY = HEAD_W'(MAX_BLOCKS);

  // Datapath widths
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 11;
  localparam int STRIDE_W   = SIZE_W + 1;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  // Reset values
  localparam logic [ADDR_W-1:0]   RST_BASE_ADDRESS = '0;
  localparam logic [STRIDE_W-1:0] RST_STRIDE       = STRIDE_W'(16);
  localparam logic [COUNT_W-1:0]  RST_BLOCK_COUNT  = COUNT_W'(1024);

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_MUL,
    ST_OUT
  } fbpa_state_t;

  typedef struct packed {
    logic take_free;   // push the given block if it is in the pool
    logic pop_link;    // hand out the head of the returned stack
    logic pop_fresh;   // hand out the next never-used block
    logic miss;        // pool exhausted
    logic load_link;   // follow the link read from the table
    logic load_prod;   // register index times stride
    logic load_out;    // load the result word
  } fbpa_cmd_t;

  typedef struct packed {
    logic head_empty;
    logic fresh_zero;
  } fbpa_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fixed_block_pool_allocator_unit.sv -----
// Top level of the fixed block pool allocator: controller plus datapath.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dpath and fbpa_ram.
//
// Usage:
//   The input channel carries one request word: in_action selects
//   allocate or free, in_block_index names the block to free and
//   in_null_pointer marks a free that names no block. A word is taken
//   when in_valid is high and in_stall is low.
//   An allocate yields one result word on the output channel: granted,
//   the block index and its byte address (base + index * stride, the
//   stride being block_size rounded up to 16). A free yields nothing.
//   Timing: a free leaves the controller idle and the next word is taken
//   right after it. An allocate from never-used blocks, or on an empty
//   pool, passes the multiply state, then the output state that loads the
//   output register; one from the returned stack first passes the link
//   state, which waits for the registered read of the link table RAM.
//   The index multiply and the 64-bit add take one stage each. The next
//   word is accepted in the cycle after the result is loaded, even while
//   it still waits. If out_stall holds a finished word, the next allocate
//   waits in its last stage until the output register is free.
//   Reset (rst_n low, synchronous) restores base 0, size 16 and 1024
//   blocks, and fills the list with every block. Any configuration
//   write rebuilds the list in the same way; write only while idle.
`default_nettype none

module fixed_block_pool_allocator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_action,
  input  wire logic [fbpa_pkg::IDX_W-1:0]      in_block_index,
  input  wire logic                            in_null_pointer,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_granted,
  output logic      [fbpa_pkg::IDX_W-1:0]      out_granted_index,
  output logic      [fbpa_pkg::ADDR_W-1:0]     out_granted_address
);

  fbpa_pkg::fbpa_cmd_t cmd;
  fbpa_pkg::fbpa_sts_t sts;

  // Sequencer: one request at a time, owns the result valid flag
  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Free list, link table, address arithmetic and result payload
  fbpa_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_block_index      (in_block_index),
    .in_null_pointer     (in_null_pointer),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_granted         (out_granted),
    .out_granted_index   (out_granted_index),
    .out_granted_address (out_granted_address)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_ctrl.sv -----
// Controller of the pool allocator: sequences one request at a time and
// owns the result valid flag. Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire fbpa_pkg::fbpa_sts_t sts,
  output fbpa_pkg::fbpa_cmd_t    cmd
);

  fbpa_pkg::fbpa_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    // drop the word once the receiver takes it
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      fbpa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == fbpa_pkg::ACT_FREE) begin
            cmd.take_free = 1'b1;
          end else if (!sts.head_empty) begin
            cmd.pop_link = 1'b1;
            state_nxt    = fbpa_pkg::ST_LINK;
          end else if (!sts.fresh_zero) begin
            cmd.pop_fresh = 1'b1;
            state_nxt     = fbpa_pkg::ST_MUL;
          end else begin
            cmd.miss  = 1'b1;
            state_nxt = fbpa_pkg::ST_MUL;
          end
        end
      end
      fbpa_pkg::ST_LINK: begin
        cmd.load_link = 1'b1;
        state_nxt     = fbpa_pkg::ST_MUL;
      end
      fbpa_pkg::ST_MUL: begin
        cmd.load_prod = 1'b1;
        state_nxt     = fbpa_pkg::ST_OUT;
      end
      fbpa_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fbpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_dpath.sv -----
// Datapath of the pool allocator: configuration registers, list head,
// fresh counter, link table RAM, address multiply-add and result word.
// Depends on fbpa_pkg and fbpa_ram.
`default_nettype none

module fbpa_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [fbpa_pkg::IDX_W-1:0]          in_block_index,
  input  wire logic                                in_null_pointer,
  input  wire fbpa_pkg::fbpa_cmd_t                 cmd,
  output fbpa_pkg::fbpa_sts_t                      sts,
  output logic                                     out_granted,
  output logic      [fbpa_pkg::IDX_W-1:0]          out_granted_index,
  output logic      [fbpa_pkg::ADDR_W-1:0]         out_granted_address
);

  logic [fbpa_pkg::ADDR_W-1:0]   base_r;
  logic [fbpa_pkg::STRIDE_W-1:0] stride_r;
  logic [fbpa_pkg::COUNT_W-1:0]  eff_count_r;
  logic [fbpa_pkg::HEAD_W-1:0]   head_r, head_nxt;
  logic [fbpa_pkg::COUNT_W-1:0]  fresh_r, fresh_nxt;
  logic [fbpa_pkg::IDX_W-1:0]    got_r;
  logic                          ok_r;
  logic [fbpa_pkg::PROD_W-1:0]   prod_r;
  logic                          granted_r;
  logic [fbpa_pkg::IDX_W-1:0]    gidx_r;
  logic [fbpa_pkg::ADDR_W-1:0]   gaddr_r;

  logic [fbpa_pkg::STRIDE_W-1:0] size_round;
  logic [fbpa_pkg::STRIDE_W-1:0] stride_nxt;
  logic [fbpa_pkg::COUNT_W-1:0]  count_raw, eff_nxt;
  logic                          free_ok;
  logic [fbpa_pkg::HEAD_W-1:0]   link_rdata;
  logic [fbpa_pkg::COUNT_W-1:0]  fresh_dec;

  // Round the requested size up to the alignment
  assign size_round = {1'b0, cfg_data[fbpa_pkg::SIZE_W-1:0]}
                      + fbpa_pkg::STRIDE_W'(fbpa_pkg::ALIGN_BYTES - 1);
  assign stride_nxt = (size_round >> fbpa_pkg::ALIGN_LG) << fbpa_pkg::ALIGN_LG;

  // Saturate the block count at the pool depth
  assign count_raw = cfg_data[fbpa_pkg::COUNT_W-1:0];
  assign eff_nxt   = (count_raw > fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS))
                     ? fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS) : count_raw;

  assign free_ok   = cmd.take_free && !in_null_pointer
                     && ({1'b0, in_block_index} < eff_count_r);
  assign fresh_dec = fresh_r - fbpa_pkg::COUNT_W'(1);

  fbpa_ram #(
    .WIDTH (fbpa_pkg::HEAD_W),
    .DEPTH (fbpa_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (free_ok),
    .waddr (in_block_index),
    .wdata (head_r),
    .raddr (head_r[fbpa_pkg::IDX_W-1:0]),
    .rdata (link_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    if (free_ok) begin
      head_nxt = {1'b0, in_block_index};
    end
    if (cmd.load_link) begin
      head_nxt = (link_rdata > fbpa_pkg::LIST_EMPTY) ? fbpa_pkg::LIST_EMPTY : link_rdata;
    end
    if (cmd.pop_fresh) begin
      fresh_nxt = fresh_dec;
    end
  end

  // List state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= fbpa_pkg::RST_BASE_ADDRESS;
      stride_r    <= fbpa_pkg::RST_STRIDE;
      eff_count_r <= fbpa_pkg::RST_BLOCK_COUNT;
      head_r      <= fbpa_pkg::LIST_EMPTY;
      fresh_r     <= fbpa_pkg::RST_BLOCK_COUNT;
    end else if (cfg_we && (cfg_index == fbpa_pkg::CFG_BASE_ADDRESS
                         || cfg_index == fbpa_pkg::CFG_BLOCK_SIZE
                         || cfg_index == fbpa_pkg::CFG_BLOCK_COUNT)) begin
      // any register write rebuilds the full list
      head_r  <= fbpa_pkg::LIST_EMPTY;
      fresh_r <= eff_count_r;
      case (cfg_index)
        fbpa_pkg::CFG_BASE_ADDRESS: base_r <= cfg_data;
        fbpa_pkg::CFG_BLOCK_SIZE:   stride_r <= stride_nxt;
        fbpa_pkg::CFG_BLOCK_COUNT: begin
          eff_count_r <= eff_nxt;
          fresh_r     <= eff_nxt;
        end
        default: base_r <= base_r;
      endcase
    end else begin
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.pop_link) begin
      got_r <= head_r[fbpa_pkg::IDX_W-1:0];
      ok_r  <= 1'b1;
    end else if (cmd.pop_fresh) begin
      got_r <= fresh_dec[fbpa_pkg::IDX_W-1:0];
      ok_r  <= 1'b1;
    end else if (cmd.miss) begin
      got_r <= '0;
      ok_r  <= 1'b0;
    end
    if (cmd.load_prod) begin
      prod_r <= fbpa_pkg::PROD_W'(got_r) * fbpa_pkg::PROD_W'(stride_r);
    end
    if (cmd.load_out) begin
      granted_r <= ok_r;
      gidx_r    <= ok_r ? got_r : '0;
      gaddr_r   <= ok_r ? base_r + fbpa_pkg::ADDR_W'(prod_r) : '0;
    end
  end

  assign sts.head_empty    = (head_r == fbpa_pkg::LIST_EMPTY);
  assign sts.fresh_zero    = (fresh_r == '0);
  assign out_granted         = granted_r;
  assign out_granted_index   = gidx_r;
  assign out_granted_address = gaddr_r;

endmodule

`default_nettype wire

// ----- rtl/core/fbpa_checker.sv -----
// Port-level checker for the pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_unit.
`default_nettype none

module fbpa_port_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        in_action,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_granted,
  input wire logic [fbpa_pkg::IDX_W-1:0]  out_granted_index,
  input wire logic [fbpa_pkg::ADDR_W-1:0] out_granted_address
);

  // no result word survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a refused allocate reports zero index and zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_granted_index == '0 && out_granted_address == '0)
    else $error("non-zero payload on refused allocate");

  // a free leaves the block ready for the next word
  a_free_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == fbpa_pkg::ACT_FREE |=> !in_stall)
    else $error("busy after a free");

  // an allocate keeps the block busy for its address stages
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == fbpa_pkg::ACT_ALLOC |=> in_stall ##1 in_stall)
    else $error("new word taken during an allocate");

endmodule

bind fixed_block_pool_allocator_unit fbpa_port_checker u_fbpa_port_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_action           (in_action),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_granted         (out_granted),
  .out_granted_index   (out_granted_index),
  .out_granted_address (out_granted_address)
);

`default_nettype wire

// ----- tb/fbpa_checker.sv -----
// Grant checker for the fixed block pool allocator: follows the config port
// and both channels, predicts every allocate result and compares it.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_checker
  import fbpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  in_action,
  input  wire logic [IDX_W-1:0]      in_block_index,
  input  wire logic                  in_null_pointer,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic                  out_granted,
  input  wire logic [IDX_W-1:0]      out_granted_index,
  input  wire logic [ADDR_W-1:0]     out_granted_address,
  output int                         error_count,
  output int                         pending_words,
  output int                         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] addr;
  } grant_word_t;

  grant_word_t grant_queue[$];

  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  req_size;
  logic [COUNT_W-1:0] req_count;
  logic [HEAD_W-1:0]  link_next [MAX_BLOCKS];
  logic [HEAD_W-1:0]  stack_top;
  logic [COUNT_W-1:0] untouched_left;

  int errors  = 0;
  int checked = 0;
  int waiting = 0;

  assign error_count   = errors;
  assign pending_words = waiting;
  assign results_seen  = checked;

  function automatic logic [COUNT_W-1:0] live_blocks();
    return (req_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : req_count;
  endfunction

  function automatic logic [ADDR_W-1:0] block_stride();
    logic [ADDR_W-1:0] padded;
    padded = ADDR_W'(req_size) + ADDR_W'(ALIGN_BYTES - 1);
    return (padded / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // Put every block back: nothing returned, all blocks untouched.
  task automatic restock();
    stack_top      = LIST_EMPTY;
    untouched_left = live_blocks();
  endtask

  task automatic take_request(logic act, logic [IDX_W-1:0] idx, logic is_null);
    grant_word_t w;
    logic [HEAD_W-1:0] got;
    if (act == ACT_FREE) begin
      if (!is_null && COUNT_W'(idx) < live_blocks()) begin
        link_next[idx] = stack_top;
        stack_top      = HEAD_W'(idx);
      end
    end else begin
      w   = '0;
      got = '0;
      if (stack_top < LIST_EMPTY) begin
        got       = stack_top;
        stack_top = link_next[got[IDX_W-1:0]];
        w.granted = 1'b1;
      end else if (untouched_left != '0) begin
        untouched_left = untouched_left - COUNT_W'(1);
        got            = HEAD_W'(untouched_left);
        w.granted      = 1'b1;
      end
      if (w.granted) begin
        w.index = got[IDX_W-1:0];
        w.addr  = pool_base + ADDR_W'(got) * block_stride();
      end
      grant_queue = {grant_queue, w};
    end
  endtask

  task automatic check_result();
    grant_word_t want;
    checked++;
    if (grant_queue.size() == 0) begin
      errors++;
      $display("%0t: unexpected result granted=%0b index=%0d address=%h", $time,
               out_granted, out_granted_index, out_granted_address);
    end else begin
      want = grant_queue.pop_front();
      if (out_granted !== want.granted) begin
        errors++;
        $display("%0t: granted expected %0b actual %0b", $time, want.granted, out_granted);
      end
      if (out_granted_index !== want.index) begin
        errors++;
        $display("%0t: granted_index expected %0d actual %0d", $time, want.index,
                 out_granted_index);
      end
      if (out_granted_address !== want.addr) begin
        errors++;
        $display("%0t: granted_address expected %h actual %h", $time, want.addr,
                 out_granted_address);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pool_base = RST_BASE_ADDRESS;
      req_size  = SIZE_W'(RST_STRIDE);
      req_count = RST_BLOCK_COUNT;
      restock();
      grant_queue.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_request(in_action, in_block_index, in_null_pointer);
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: begin
            pool_base = cfg_data;
            restock();
          end
          CFG_BLOCK_SIZE: begin
            req_size = cfg_data[SIZE_W-1:0];
            restock();
          end
          CFG_BLOCK_COUNT: begin
            req_count = cfg_data[COUNT_W-1:0];
            restock();
          end
          default: ;
        endcase
      end
    end
    waiting = grant_queue.size();
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the pool allocator testbench: clock, reset, config writes and
// request stimulus with random idling on both channels, plus the verdict.
// Depends on fbpa_pkg, fixed_block_pool_allocator_unit and fbpa_checker.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int IDLE_PCT      = 14;
  // Idle time after the last owed result, longer than the slowest allocate.
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = CFG_BASE_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_action       = ACT_ALLOC;
  logic [IDX_W-1:0]      in_block_index  = '0;
  logic                  in_null_pointer = 1'b0;
  logic                  out_stall       = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_granted;
  logic [IDX_W-1:0]      out_granted_index;
  logic [ADDR_W-1:0]     out_granted_address;

  int error_count;
  int pending_words;
  int results_seen;
  int cycle_count    = 0;
  int words_sent     = 0;
  int settings_used  = 0;
  int pool_blocks    = MAX_BLOCKS;  // blocks in the pool under the current setting
  bit calm           = 1'b0;        // high during the stretch with no idling

  fixed_block_pool_allocator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_block_index      (in_block_index),
    .in_null_pointer     (in_null_pointer),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_granted_index   (out_granted_index),
    .out_granted_address (out_granted_address)
  );

  fbpa_checker grant_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_block_index      (in_block_index),
    .in_null_pointer     (in_null_pointer),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_granted_index   (out_granted_index),
    .out_granted_address (out_granted_address),
    .error_count         (error_count),
    .pending_words       (pending_words),
    .results_seen        (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Abort a hung run: a lost result or a stuck stall never lets the main
  // sequence reach its verdict.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still owed", cycle_count, pending_words);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: stall at random, except during the calm stretch.
  always @(negedge clk) out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

  // Present one request word and hold it until the block takes it. Idle
  // cycles go in front of the word, so valid is never dropped under it.
  task automatic send_word(logic act, logic [IDX_W-1:0] idx, logic is_null);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_block_index  <= idx;
    in_null_pointer <= is_null;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Allocate with junk in the ignored fields.
  task automatic alloc_word();
    send_word(ACT_ALLOC, IDX_W'($urandom), 1'($urandom));
  endtask

  task automatic free_word(logic [IDX_W-1:0] idx);
    send_word(ACT_FREE, idx, 1'b0);
  endtask

  // Mostly allocates and in-pool frees, which keep the list moving; the
  // rest is noise: null frees and frees that may fall outside the pool.
  task automatic random_word(int alloc_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      alloc_word();
    end else begin
      roll = $urandom_range(0, 9);
      if (roll == 0)
        send_word(ACT_FREE, IDX_W'($urandom), 1'b1);
      else if (roll == 1 || pool_blocks == 0)
        free_word(IDX_W'($urandom));
      else
        free_word(IDX_W'($urandom_range(0, pool_blocks - 1)));
    end
  endtask

  // Drop valid, drain every owed result, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    wait (pending_words == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic configure(logic [ADDR_W-1:0] base, int size, int count);
    settle();
    @(negedge clk) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_BASE_ADDRESS;
      cfg_data  <= base;
    end
    @(negedge clk) begin
      cfg_index <= CFG_BLOCK_SIZE;
      cfg_data  <= CFG_DATA_W'(size);
    end
    @(negedge clk) begin
      cfg_index <= CFG_BLOCK_COUNT;
      cfg_data  <= CFG_DATA_W'(count);
    end
    @(negedge clk) cfg_we <= 1'b0;
    pool_blocks = (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
    settings_used++;
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] base, int size, int count, int words,
                           int alloc_pct, bit no_idle);
    configure(base, size, count);
    calm = no_idle;
    repeat (words) random_word(alloc_pct);
    calm = 1'b0;
  endtask

  initial begin
    // Hold reset low from the start, release it between edges.
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    settings_used = 1;

    // Reset pool: 1024 blocks of 16 bytes at address 0.
    alloc_word();                             // top block from the untouched run
    free_word(IDX_W'(MAX_BLOCKS - 1));
    alloc_word();                             // same block back off the returned stack
    free_word('0);                            // never handed out
    free_word('0);                            // and freed again
    alloc_word();
    alloc_word();                             // double free hands block 0 out again
    alloc_word();                             // block 0 once more: the stack now loops on it
    send_word(ACT_FREE, IDX_W'(5), 1'b1);     // null free, no effect
    send_word(ACT_ALLOC, '1, 1'b1);           // ignored fields at their maximum

    // Three huge blocks near the top of memory: addresses wrap.
    configure('1 - ADDR_W'(15), 65536, 3);
    repeat (4) alloc_word();                  // drain the pool, then one miss
    free_word(IDX_W'(3));                     // just past the pool
    free_word('1);                            // far past the pool
    free_word(IDX_W'(2));
    repeat (2) alloc_word();

    // Zero block size and a count above the maximum.
    configure(ADDR_W'(64'h0000_0000_1234_5670), 0, 2047);
    repeat (3) alloc_word();
    free_word('1);
    alloc_word();

    // Random phases across a spread of pool settings.
    run_phase({$urandom, $urandom}, $urandom_range(1, 65536), MAX_BLOCKS, 120, 50, 1'b0);
    run_phase({$urandom, $urandom}, 1, 1, 60, 50, 1'b0);
    run_phase('0, 0, 0, 40, 50, 1'b0);
    run_phase('1, 65536, 2047, 100, 55, 1'b1);
    repeat (5) begin
      run_phase({$urandom, $urandom},
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 64),
                $urandom_range(1, 12), 70, $urandom_range(35, 65), 1'b0);
    end

    // Drain and give a stray late result time to show up.
    settle();

    $display("Sent %0d request words under %0d pool settings, checked %0d allocate results.",
             words_sent, settings_used, results_seen);
    $display("Pools ranged from empty to oversized, with zero, minimum and maximum strides.");
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dpath.sv
rtl/core/fixed_block_pool_allocator_unit.sv
rtl/core/fbpa_checker.sv
tb/fbpa_checker.sv
tb/testbench.sv
